// ===== hw/rtl/icsp_serial_programming_master_unit_assert.svh =====
// assertion macros for the rtl
`ifndef ICSP_SERIAL_PROGRAMMING_MASTER_UNIT_ASSERT_SVH
`define ICSP_SERIAL_PROGRAMMING_MASTER_UNIT_ASSERT_SVH

// same-cycle implication
`define ICSP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("icsp assertion failed");

// next-cycle implication
`define ICSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("icsp assertion failed");

`endif

// ===== hw/rtl/icsp_pkg.sv =====
`default_nettype none
package icsp_pkg;

	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_ENTER = 3'd1,
		OP_EXIT  = 3'd2,
		OP_CMD   = 3'd3,
		OP_WRITE = 3'd4,
		OP_READ  = 3'd5
	} op_e_t;

	localparam logic [2:0] REG_CLOCK_HIGH = 3'd0;
	localparam logic [2:0] REG_CLOCK_LOW  = 3'd1;
	localparam logic [2:0] REG_READ_VALID = 3'd2;
	localparam logic [2:0] REG_MCLR_PULSE = 3'd3;
	localparam logic [2:0] REG_ENTRY_HOLD = 3'd4;
	localparam logic [2:0] REG_ENTRY_KEY  = 3'd5;

	localparam logic [15:0] CLOCK_HIGH_RST = 16'd1;
	localparam logic [15:0] CLOCK_LOW_RST  = 16'd1;
	localparam logic [15:0] READ_VALID_RST = 16'd1;
	localparam logic [15:0] MCLR_PULSE_RST = 16'd1;
	localparam logic [15:0] ENTRY_HOLD_RST = 16'd250;
	localparam logic [31:0] ENTRY_KEY_RST  = 32'h4D434850;

	localparam logic [5:0] KEY_BITS   = 6'd32;
	localparam logic [5:0] CMD_BITS   = 6'd6;
	localparam logic [5:0] FRAME_BITS = 6'd16;

	typedef struct packed {
		logic [2:0]  mode;
		logic [5:0]  command_code;
		logic [15:0] write_word;
		logic [15:0] post_delay;
		logic        data_pin_level;
	} request_t;

	typedef struct packed {
		logic        clock_pin;
		logic        data_pin;
		logic        data_drive;
		logic        mclr_pin;
		logic        mclr_drive;
		logic        busy_res;
		logic        done_res;
		logic [14:0] read_word;
		logic        rejected;
	} response_t;

	typedef struct packed {
		op_e_t       op;
		logic        start;
		logic [5:0]  cmd;
		logic [15:0] word;
		logic [15:0] delay;
		logic        level;
	} task_t;

	typedef struct packed {
		logic [15:0] clock_high;
		logic [15:0] clock_low;
		logic [15:0] read_valid;
		logic [15:0] mclr_pulse;
		logic [15:0] entry_hold;
		logic [31:0] entry_key;
	} cfg_t;

	typedef struct packed {
		logic clk;
		logic dat;
		logic ddrv;
		logic mclr;
		logic mdrv;
	} pins_t;

endpackage
`default_nettype wire

// ===== hw/rtl/icsp_front.sv =====
`default_nettype none
module icsp_front import icsp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire request_t request,
	output logic          task_valid,
	output task_t         task_item,
	input  wire logic     task_take
);

	task_t      entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       wr_en;
	task_t      cls;

	always_comb begin
		cls.start = 1'b1;
		unique case (request.mode)
			3'(OP_ENTER): cls.op = OP_ENTER;
			3'(OP_EXIT):  cls.op = OP_EXIT;
			3'(OP_CMD):   cls.op = OP_CMD;
			3'(OP_WRITE): cls.op = OP_WRITE;
			3'(OP_READ):  cls.op = OP_READ;
			default: begin
				cls.op    = OP_IDLE;
				cls.start = 1'b0;
			end
		endcase
		cls.cmd   = request.command_code;
		cls.word  = request.write_word;
		cls.delay = request.post_delay;
		cls.level = request.data_pin_level;
	end

	assign full       = (count_q == 2'd2);
	assign wr_en      = push && !full;
	assign task_valid = (count_q != 2'd0);
	assign task_item  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= ~wr_q;
			end
			if (task_take) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + 2'(wr_en) - 2'(task_take);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/icsp_seq.sv =====
`default_nettype none
`include "icsp_serial_programming_master_unit_assert.svh"
module icsp_seq import icsp_pkg::*; #(
	parameter int DELAY_WIDTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  step,
	input  wire task_t t,
	output response_t res
);

	localparam logic [2:0] EN_PULSE     = 3'd0;
	localparam logic [2:0] EN_HOLD      = 3'd1;
	localparam logic [2:0] EN_SETUP     = 3'd2;
	localparam logic [2:0] EN_HIGH      = 3'd3;
	localparam logic [2:0] EN_LAST_LOW  = 3'd4;
	localparam logic [2:0] EN_LAST_HIGH = 3'd5;
	localparam logic [2:0] SH_HIGH      = 3'd0;
	localparam logic [2:0] SH_LOW       = 3'd1;
	localparam logic [2:0] SH_WAIT      = 3'd2;
	localparam logic [2:0] RD_HIGH      = 3'd0;
	localparam logic [2:0] RD_VALID     = 3'd1;
	localparam logic [2:0] RD_LOW       = 3'd2;

	op_e_t                  op_q, n_op;
	logic [2:0]             phase_q, n_phase;
	logic [5:0]             bit_q, n_bit, nb;
	logic [31:0]            shift_q, n_shift;
	logic [DELAY_WIDTH-1:0] wait_q, n_wait, wc;
	logic [15:0]            rshift_q, n_rshift;
	logic [15:0]            pdelay_q, n_pdelay;
	logic [14:0]            rword_q, n_rword;
	pins_t                  pins_q, n_pins;
	logic                   done;
	logic                   rej;
	logic                   fin;
	logic [5:0]             count;

	function automatic logic [DELAY_WIDTH-1:0] ld(input logic [15:0] n);
		logic [DELAY_WIDTH-1:0] w;
		w = DELAY_WIDTH'(n);
		return (w == '0) ? DELAY_WIDTH'(1) : w;
	endfunction

	always_comb begin
		n_op     = op_q;
		n_phase  = phase_q;
		n_bit    = bit_q;
		n_shift  = shift_q;
		n_wait   = wait_q;
		n_rshift = rshift_q;
		n_pdelay = pdelay_q;
		n_rword  = rword_q;
		n_pins   = pins_q;
		done     = 1'b0;
		rej      = 1'b0;
		fin      = 1'b0;
		nb       = bit_q + 6'd1;
		wc       = wait_q;
		count    = (op_q == OP_CMD) ? CMD_BITS : FRAME_BITS;
		if (op_q != OP_IDLE) begin
			rej = t.start;
			if (wait_q != '0) begin
				wc = wait_q - DELAY_WIDTH'(1);
			end
			n_wait = wc;
			if (wc == '0) begin
				unique case (op_q)
					OP_ENTER: begin
						if (phase_q == EN_PULSE) begin
							n_pins.mclr = 1'b0;
							n_phase     = EN_HOLD;
							n_wait      = ld(cfg.entry_hold);
						end else if (phase_q == EN_HOLD) begin
							n_pins.dat = shift_q[0];
							n_phase    = EN_SETUP;
							n_wait     = ld(cfg.clock_low);
						end else if (phase_q == EN_SETUP) begin
							n_pins.clk = 1'b1;
							n_phase    = EN_HIGH;
							n_wait     = ld(cfg.clock_high);
						end else if (phase_q == EN_HIGH) begin
							n_pins.clk = 1'b0;
							n_shift    = shift_q >> 1;
							n_bit      = nb;
							if (nb < KEY_BITS) begin
								n_pins.dat = n_shift[0];
								n_phase    = EN_SETUP;
							end else begin
								n_pins.dat = 1'b0;
								n_phase    = EN_LAST_LOW;
							end
							n_wait = ld(cfg.clock_low);
						end else if (phase_q == EN_LAST_LOW) begin
							n_pins.clk = 1'b1;
							n_phase    = EN_LAST_HIGH;
							n_wait     = ld(cfg.clock_high);
						end else begin
							n_pins.clk = 1'b0;
							fin        = 1'b1;
						end
					end
					OP_CMD, OP_WRITE: begin
						if (phase_q == SH_HIGH) begin
							n_pins.clk = 1'b0;
							n_phase    = SH_LOW;
							n_wait     = ld(cfg.clock_low);
						end else if (phase_q == SH_LOW) begin
							n_shift = shift_q >> 1;
							n_bit   = nb;
							if (nb < count) begin
								n_pins.clk = 1'b1;
								n_pins.dat = n_shift[0];
								n_phase    = SH_HIGH;
								n_wait     = ld(cfg.clock_high);
							end else begin
								n_pins.dat = 1'b0;
								if (op_q == OP_WRITE) begin
									fin = 1'b1;
								end else begin
									n_phase = SH_WAIT;
									n_wait  = ld(pdelay_q);
								end
							end
						end else begin
							fin = 1'b1;
						end
					end
					OP_READ: begin
						if (phase_q == RD_HIGH) begin
							n_phase = RD_VALID;
							n_wait  = ld(cfg.read_valid);
						end else if (phase_q == RD_VALID) begin
							if (bit_q < FRAME_BITS) begin
								n_rshift[bit_q[3:0]] = rshift_q[bit_q[3:0]] | t.level;
							end
							n_pins.clk = 1'b0;
							n_phase    = RD_LOW;
							n_wait     = ld(cfg.clock_low);
						end else begin
							n_bit = nb;
							if (nb < FRAME_BITS) begin
								n_pins.clk = 1'b1;
								n_phase    = RD_HIGH;
								n_wait     = ld(cfg.clock_high);
							end else begin
								n_pins.ddrv = 1'b1;
								n_rword     = rshift_q[15:1];
								fin         = 1'b1;
							end
						end
					end
					default: fin = 1'b1;
				endcase
			end
			if (fin) begin
				n_op    = OP_IDLE;
				n_phase = 3'd0;
				done    = 1'b1;
			end
		end else if (t.start) begin
			n_phase = 3'd0;
			n_bit   = 6'd0;
			unique case (t.op)
				OP_ENTER: begin
					n_op   = OP_ENTER;
					n_shift = cfg.entry_key;
					n_pins = '{clk: 1'b0, dat: 1'b0, ddrv: 1'b1, mclr: 1'b1, mdrv: 1'b1};
					n_wait = ld(cfg.mclr_pulse);
				end
				OP_EXIT: begin
					n_pins.clk  = 1'b0;
					n_pins.dat  = 1'b0;
					n_pins.mclr = 1'b0;
					n_pins.mdrv = 1'b0;
					done        = 1'b1;
				end
				OP_CMD, OP_WRITE: begin
					n_op        = t.op;
					n_shift     = (t.op == OP_CMD) ? {26'd0, t.cmd} : {16'd0, t.word[14:0], 1'b0};
					n_pdelay    = t.delay;
					n_pins.clk  = 1'b1;
					n_pins.dat  = n_shift[0];
					n_pins.ddrv = 1'b1;
					n_wait      = ld(cfg.clock_high);
				end
				OP_READ: begin
					n_op        = OP_READ;
					n_rshift    = 16'd0;
					n_pins.ddrv = 1'b0;
					n_pins.clk  = 1'b1;
					n_wait      = ld(cfg.clock_high);
				end
				default: n_op = op_q;
			endcase
		end
		res.clock_pin  = n_pins.clk;
		res.data_pin   = n_pins.dat;
		res.data_drive = n_pins.ddrv;
		res.mclr_pin   = n_pins.mclr;
		res.mclr_drive = n_pins.mdrv;
		res.busy_res   = (n_op != OP_IDLE);
		res.done_res   = done;
		res.read_word  = n_rword;
		res.rejected   = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= OP_IDLE;
			phase_q  <= 3'd0;
			bit_q    <= 6'd0;
			shift_q  <= 32'd0;
			wait_q   <= '0;
			rshift_q <= 16'd0;
			pdelay_q <= 16'd0;
			rword_q  <= 15'd0;
			pins_q   <= '0;
		end else if (step) begin
			op_q     <= n_op;
			phase_q  <= n_phase;
			bit_q    <= n_bit;
			shift_q  <= n_shift;
			wait_q   <= n_wait;
			rshift_q <= n_rshift;
			pdelay_q <= n_pdelay;
			rword_q  <= n_rword;
			pins_q   <= n_pins;
		end
	end

	`ICSP_ASSERT_NOW(a_wait_loaded, op_q != OP_IDLE, wait_q != '0)
	`ICSP_ASSERT_NOW(a_done_idle, step && res.done_res, !res.busy_res)
	`ICSP_ASSERT_NOW(a_reject_busy, step && res.rejected, op_q != OP_IDLE)
	`ICSP_ASSERT_NEXT(a_read_release, step && op_q == OP_IDLE && t.start && t.op == OP_READ,
		!pins_q.ddrv && op_q == OP_READ)

endmodule
`default_nettype wire

// ===== hw/rtl/icsp_rsp_q.sv =====
`default_nettype none
module icsp_rsp_q import icsp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  wire response_t wr_data,
	output logic           room,
	output logic           empty,
	input  wire logic      pop,
	output response_t      response
);

	response_t  entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       rd_en;

	assign room     = (count_q != 2'd2);
	assign empty    = (count_q == 2'd0);
	assign rd_en    = pop && !empty;
	assign response = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= ~wr_q;
			end
			if (rd_en) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/icsp_serial_programming_master_unit.sv =====
// channel   | direction | handshake        | payload
// request   | in        | push / full      | request_t (mode, code, word, delay, pin level)
// response  | out       | pop / empty      | response_t (pins, busy, done, read word, reject)
// config    | in        | apb psel/penable | six registers at 4*i
// one tick item per cycle while neither queue stalls; each is registered in both queues
// the sequencer takes one queued item per cycle while the result queue has room
// each side stalls on its own through two-entry queues at either end
// reset is asynchronous, active low, and needs no clearing pass
`default_nettype none
module icsp_serial_programming_master_unit import icsp_pkg::*; #(
	parameter int DELAY_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire request_t    request,
	output logic             empty,
	input  wire logic        pop,
	output response_t        response,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t       cfg_q;
	logic [2:0] index;
	logic       task_valid;
	task_t      task_item;
	logic       room;
	logic       take;
	response_t  seq_res;

	assign pready = 1'b1;
	assign index  = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_high <= CLOCK_HIGH_RST;
			cfg_q.clock_low  <= CLOCK_LOW_RST;
			cfg_q.read_valid <= READ_VALID_RST;
			cfg_q.mclr_pulse <= MCLR_PULSE_RST;
			cfg_q.entry_hold <= ENTRY_HOLD_RST;
			cfg_q.entry_key  <= ENTRY_KEY_RST;
		end else if (psel && penable && pwrite) begin
			unique case (index)
				REG_CLOCK_HIGH: cfg_q.clock_high <= pwdata[15:0];
				REG_CLOCK_LOW:  cfg_q.clock_low  <= pwdata[15:0];
				REG_READ_VALID: cfg_q.read_valid <= pwdata[15:0];
				REG_MCLR_PULSE: cfg_q.mclr_pulse <= pwdata[15:0];
				REG_ENTRY_HOLD: cfg_q.entry_hold <= pwdata[15:0];
				REG_ENTRY_KEY:  cfg_q.entry_key  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (index)
			REG_CLOCK_HIGH: prdata = {16'd0, cfg_q.clock_high};
			REG_CLOCK_LOW:  prdata = {16'd0, cfg_q.clock_low};
			REG_READ_VALID: prdata = {16'd0, cfg_q.read_valid};
			REG_MCLR_PULSE: prdata = {16'd0, cfg_q.mclr_pulse};
			REG_ENTRY_HOLD: prdata = {16'd0, cfg_q.entry_hold};
			REG_ENTRY_KEY:  prdata = cfg_q.entry_key;
			default:        prdata = 32'd0;
		endcase
	end

	assign take = task_valid && room;

	icsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.request    (request),
		.task_valid (task_valid),
		.task_item  (task_item),
		.task_take  (take)
	);

	icsp_seq #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (take),
		.t      (task_item),
		.res    (seq_res)
	);

	icsp_rsp_q u_rsp_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (take),
		.wr_data  (seq_res),
		.room     (room),
		.empty    (empty),
		.pop      (pop),
		.response (response)
	);

endmodule
`default_nettype wire
